// ===== src/hssq_pkg.sv =====
// ----------------------------------------------------------------------------
// hssq_pkg
// Shared types, codes and helpers for the half-step stepper sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package hssq_pkg;

    // Width of the delay counter and its reload value
    localparam int DELAY_WIDTH = 16;
    localparam int IN_DELAY_W  = 16;
    localparam int DELAY_CMP_W = (DELAY_WIDTH > IN_DELAY_W) ? DELAY_WIDTH : IN_DELAY_W;
    localparam int STEPS_W     = 19;
    localparam int PROD_W      = 23;

    localparam logic [PROD_W-1:0] STEP_SCALE = PROD_W'(91);

    // Item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    typedef struct packed {
        logic [1:0]            kind;
        logic [15:0]           angle;
        logic                  direction;
        logic [IN_DELAY_W-1:0] step_ticks;
    } hssq_item_t;

    typedef struct packed {
        logic [3:0] coils;
        logic       busy_res;
        logic       done_res;
    } hssq_result_t;

    // Half-step coil pattern, bit0 = IN1 .. bit3 = IN4
    function automatic logic [3:0] drive_for(input logic [2:0] phase, input logic rev);
        logic [2:0] p;
        logic [3:0] c;
        p = rev ? (3'd7 - phase) : phase;
        unique case (p)
            3'd0: c = 4'h1;
            3'd1: c = 4'h5;
            3'd2: c = 4'h4;
            3'd3: c = 4'h6;
            3'd4: c = 4'h2;
            3'd5: c = 4'hA;
            3'd6: c = 4'h8;
            3'd7: c = 4'h9;
            default: c = 4'h0;
        endcase
        return c;
    endfunction

    // Saturate to the counter width; zero acts as one tick
    function automatic logic [DELAY_WIDTH-1:0] sat_delay(input logic [IN_DELAY_W-1:0] d);
        logic [DELAY_CMP_W-1:0] ext;
        logic [DELAY_CMP_W-1:0] lim;
        ext = DELAY_CMP_W'(d);
        lim = DELAY_CMP_W'({DELAY_WIDTH{1'b1}});
        if (ext > lim)
        begin
            ext = lim;
        end
        if (ext == '0)
        begin
            ext = DELAY_CMP_W'(1);
        end
        return DELAY_WIDTH'(ext);
    endfunction

endpackage

`default_nettype wire

// ===== src/hssq_in_stage.sv =====
// ----------------------------------------------------------------------------
// hssq_in_stage
// Input register: holds one command beat until the step logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hssq_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire hssq_pkg::hssq_item_t cmd,
    input  wire logic               advance,
    output logic                    item_valid,
    output hssq_pkg::hssq_item_t    item
);

    logic                 vld_reg;
    logic                 vld_next;
    hssq_pkg::hssq_item_t item_reg;
    logic                 take;

    assign cmd_stall = vld_reg && !advance;
    assign take      = cmd_valid && !cmd_stall;

    always_comb
    begin
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= cmd;
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== src/hssq_step_logic.sv =====
// ----------------------------------------------------------------------------
// hssq_step_logic
// Motion state registers and the per-beat next-state update.
// ----------------------------------------------------------------------------
`default_nettype none

module hssq_step_logic (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire hssq_pkg::hssq_item_t item,
    output hssq_pkg::hssq_result_t    result
);

    logic [3:0]                       coil_reg,    coil_next;
    logic [2:0]                       phase_reg,   phase_next;
    logic [hssq_pkg::STEPS_W-1:0]     steps_reg,   steps_next;
    logic [hssq_pkg::DELAY_WIDTH-1:0] dleft_reg,   dleft_next;
    logic [hssq_pkg::DELAY_WIDTH-1:0] reload_reg,  reload_next;
    logic                             rev_reg,     rev_next;
    logic                             run_reg,     run_next;
    logic                             done;

    logic [hssq_pkg::PROD_W-1:0]      prod;
    logic [hssq_pkg::STEPS_W-1:0]     total;
    logic [hssq_pkg::DELAY_WIDTH-1:0] dly_sat;
    logic [hssq_pkg::DELAY_WIDTH-1:0] dec;
    logic [2:0]                       phase_inc;

    // angle * 91 / 16
    assign prod      = hssq_pkg::PROD_W'(item.angle) * hssq_pkg::STEP_SCALE;
    assign total     = prod[hssq_pkg::PROD_W-1:4];
    assign dly_sat   = hssq_pkg::sat_delay(item.step_ticks);
    assign dec       = (dleft_reg != '0) ? (dleft_reg - 1'b1) : dleft_reg;
    assign phase_inc = phase_reg + 3'd1;

    always_comb
    begin
        coil_next   = coil_reg;
        phase_next  = phase_reg;
        steps_next  = steps_reg;
        dleft_next  = dleft_reg;
        reload_next = reload_reg;
        rev_next    = rev_reg;
        run_next    = run_reg;
        done        = 1'b0;
        unique case (item.kind)
            hssq_pkg::KIND_START:
            begin
                reload_next = dly_sat;
                rev_next    = item.direction;
                phase_next  = 3'd0;
                if (total == '0)
                begin
                    coil_next  = 4'h0;
                    steps_next = '0;
                    dleft_next = '0;
                    run_next   = 1'b0;
                    done       = 1'b1;
                end
                else
                begin
                    coil_next  = hssq_pkg::drive_for(3'd0, item.direction);
                    steps_next = total - 1'b1;
                    dleft_next = dly_sat;
                    run_next   = 1'b1;
                end
            end
            hssq_pkg::KIND_STOP:
            begin
                coil_next  = 4'h0;
                done       = run_reg;
                run_next   = 1'b0;
                steps_next = '0;
                dleft_next = '0;
            end
            hssq_pkg::KIND_TICK:
            begin
                if (run_reg)
                begin
                    dleft_next = dec;
                    if (dec == '0)
                    begin
                        if (steps_reg == '0)
                        begin
                            coil_next = 4'h0;
                            run_next  = 1'b0;
                            done      = 1'b1;
                        end
                        else
                        begin
                            phase_next = phase_inc;
                            coil_next  = hssq_pkg::drive_for(phase_inc, rev_reg);
                            steps_next = steps_reg - 1'b1;
                            dleft_next = reload_reg;
                        end
                    end
                end
            end
            default:
            begin
                done = 1'b0;   // unused kind: no change
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coil_reg   <= 4'h0;
            phase_reg  <= 3'd0;
            steps_reg  <= '0;
            dleft_reg  <= '0;
            reload_reg <= '0;
            rev_reg    <= 1'b0;
            run_reg    <= 1'b0;
        end
        else if (advance)
        begin
            coil_reg   <= coil_next;
            phase_reg  <= phase_next;
            steps_reg  <= steps_next;
            dleft_reg  <= dleft_next;
            reload_reg <= reload_next;
            rev_reg    <= rev_next;
            run_reg    <= run_next;
        end
    end

    assign result.coils    = coil_next;
    assign result.busy_res = run_next;
    assign result.done_res = done;

endmodule

`default_nettype wire

// ===== src/hssq_out_stage.sv =====
// ----------------------------------------------------------------------------
// hssq_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hssq_out_stage (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   advance,
    input  wire hssq_pkg::hssq_result_t result,
    output logic                        res_valid,
    input  wire logic                   res_stall,
    output hssq_pkg::hssq_result_t      res
);

    logic                   vld_reg;
    logic                   vld_next;
    hssq_pkg::hssq_result_t res_reg;

    always_comb
    begin
        if (advance)
        begin
            vld_next = 1'b1;
        end
        else if (!res_stall)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign res_valid = vld_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== src/half_step_stepper_sequencer.sv =====
// ----------------------------------------------------------------------------
// half_step_stepper_sequencer
// Eight-phase half-step sequencer for a four-coil unipolar stepper.
// ----------------------------------------------------------------------------
// Each command beat (tick, start or stop) yields exactly one result beat
// carrying the coil drive, busy and a one-beat done flag. A start loads
// angle*91/16 steps, drives phase 0 at once and advances one phase every
// step_ticks ticks (0 counts as 1); reverse direction walks the pattern
// backwards. The block takes one beat per cycle while cmd_stall is low: a
// beat lands in the input register, and when it advances the step logic
// updates the motion state and writes the result register. The input
// register keeps accepting while a result waits in the output register;
// only when both are full and the sink stalls does cmd_stall rise.
`default_nettype none

module half_step_stepper_sequencer (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    output logic                        cmd_stall,
    input  wire hssq_pkg::hssq_item_t   cmd,
    output logic                        res_valid,
    input  wire logic                   res_stall,
    output hssq_pkg::hssq_result_t      res
);

    logic                   item_valid;
    hssq_pkg::hssq_item_t   item;
    hssq_pkg::hssq_result_t result;
    logic                   advance;

    // Move the held beat forward when the result register is free or draining
    assign advance = item_valid && (!res_valid || !res_stall);

    hssq_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    hssq_step_logic u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    hssq_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .result    (result),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // Coils are energized exactly while a motion runs
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.busy_res == (res.coils != 4'h0)))
        else $error("coil drive disagrees with busy");

    // A beat that ends a motion never reports busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.done_res) |-> !res.busy_res)
        else $error("done with busy set");

    // Input backpressure only comes from a stalled, full result register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (res_valid && res_stall && item_valid))
        else $error("input stalled without output backpressure");

    // A held beat always reaches the result register once it advances
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid)
        else $error("advanced beat lost");

endmodule

`default_nettype wire
